// File: rtl/core/sbce_pkg.sv
// shared types and constants for the sprite blit with channel expansion
package sbce_pkg;

    localparam int SIZE_W    = 13;
    localparam int CHAN_W    = 3;
    localparam int POS_W     = 12;
    localparam int ADDR_W    = 26;
    localparam int BYTE_W    = 8;
    localparam int NUM_CH    = 4;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_CHANNELS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_CHANS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_X        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_Y        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPR_W           = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPR_H           = 3'd6;

    // register reset values
    localparam logic [SIZE_W-1:0] RST_ATLAS_WIDTH   = 13'd4096;
    localparam logic [CHAN_W-1:0] RST_CHANNELS      = 3'd4;
    localparam logic [POS_W-1:0]  RST_POS           = 12'd0;
    localparam logic [SIZE_W-1:0] RST_SPRITE_SIZE   = 13'd1;

    // channel counts with special meaning
    localparam logic [CHAN_W-1:0] CH_GRAY      = 3'd1;
    localparam logic [CHAN_W-1:0] CH_RGB       = 3'd3;
    localparam logic [CHAN_W-1:0] CH_RGBA      = 3'd4;
    localparam logic [BYTE_W-1:0] OPAQUE       = 8'd255;

    typedef logic [NUM_CH-1:0][BYTE_W-1:0] pix_bytes_t;

    typedef struct packed {
        logic [SIZE_W-1:0] atlas_width;
        logic [CHAN_W-1:0] atlas_channels;
        logic [CHAN_W-1:0] src_chans;
        logic [POS_W-1:0]  sprite_x;
        logic [POS_W-1:0]  sprite_y;
    } cfg_t;

    typedef struct packed {
        pix_bytes_t        data;
        logic [NUM_CH-1:0] mask;
        logic              last;
    } pix_t;

endpackage

// File: rtl/core/sbce_regs.sv
// configuration register file and sprite size clamping
module sbce_regs #(
    parameter int MAX_SIDE = 4096,
    parameter int CNT_W    = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [sbce_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sbce_pkg::SIZE_W-1:0]        cfg_data,
    output sbce_pkg::cfg_t                     cfg,
    output logic [CNT_W-1:0]                   last_col,
    output logic [CNT_W-1:0]                   last_row
);
    import sbce_pkg::*;

    localparam int CMP_W = (CNT_W + 1 > SIZE_W) ? CNT_W + 1 : SIZE_W;
    localparam logic [CMP_W-1:0] MAX_EXT  = CMP_W'(MAX_SIDE);
    localparam logic [CNT_W-1:0] MAX_LAST = CNT_W'(MAX_SIDE - 1);

    logic [SIZE_W-1:0] atlas_width_reg;
    logic [CHAN_W-1:0] atlas_channels_reg;
    logic [CHAN_W-1:0] src_chans_reg;
    logic [POS_W-1:0]  sprite_x_reg;
    logic [POS_W-1:0]  sprite_y_reg;
    logic [SIZE_W-1:0] spr_w_reg;
    logic [SIZE_W-1:0] spr_h_reg;
    logic [CMP_W-1:0]  width_ext;
    logic [CMP_W-1:0]  height_ext;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atlas_width_reg     <= RST_ATLAS_WIDTH;
            atlas_channels_reg  <= RST_CHANNELS;
            src_chans_reg       <= RST_CHANNELS;
            sprite_x_reg        <= RST_POS;
            sprite_y_reg        <= RST_POS;
            spr_w_reg           <= RST_SPRITE_SIZE;
            spr_h_reg           <= RST_SPRITE_SIZE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ATLAS_WIDTH:     atlas_width_reg     <= cfg_data;
                REG_ATLAS_CHANNELS:  atlas_channels_reg  <= cfg_data[CHAN_W-1:0];
                REG_SRC_CHANS:       src_chans_reg       <= cfg_data[CHAN_W-1:0];
                REG_SPRITE_X:        sprite_x_reg        <= cfg_data[POS_W-1:0];
                REG_SPRITE_Y:        sprite_y_reg        <= cfg_data[POS_W-1:0];
                REG_SPR_W:           spr_w_reg           <= cfg_data;
                REG_SPR_H:           spr_h_reg           <= cfg_data;
                default:             ;
            endcase
        end
    end

    assign cfg.atlas_width     = atlas_width_reg;
    assign cfg.atlas_channels  = atlas_channels_reg;
    assign cfg.src_chans       = src_chans_reg;
    assign cfg.sprite_x        = sprite_x_reg;
    assign cfg.sprite_y        = sprite_y_reg;

    assign width_ext  = CMP_W'(spr_w_reg);
    assign height_ext = CMP_W'(spr_h_reg);

    // last column index, zero size taken as one, oversize taken as the max side
    always_comb
    begin
        priority if (width_ext == '0)
            last_col = '0;
        else if (width_ext > MAX_EXT)
            last_col = MAX_LAST;
        else
            last_col = CNT_W'(width_ext - CMP_W'(1));
    end

    // last row index, same clamping
    always_comb
    begin
        priority if (height_ext == '0)
            last_row = '0;
        else if (height_ext > MAX_EXT)
            last_row = MAX_LAST;
        else
            last_row = CNT_W'(height_ext - CMP_W'(1));
    end

endmodule

// File: rtl/core/sbce_front.sv
// pixel counters, channel conversion and the input stage register
module sbce_front #(
    parameter int CNT_W = 12,
    parameter int RS_W  = 13
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  sbce_pkg::pix_bytes_t     src,
    input  sbce_pkg::cfg_t           cfg,
    input  logic [CNT_W-1:0]         last_col,
    input  logic [CNT_W-1:0]         last_row,
    input  logic                     s2_ready,
    output logic                     s1_valid,
    output sbce_pkg::pix_t           s1_pix,
    output logic [RS_W-1:0]          s1_sum_row,
    output logic [RS_W-1:0]          s1_sum_col
);
    import sbce_pkg::*;

    logic [CNT_W-1:0]  col_reg;
    logic [CNT_W-1:0]  row_reg;
    logic [CNT_W-1:0]  col_next;
    logic [CNT_W-1:0]  row_next;
    logic              s1_valid_reg;
    pix_t              s1_pix_reg;
    pix_t              pix_next;
    logic [RS_W-1:0]   sum_row_reg;
    logic [RS_W-1:0]   sum_col_reg;
    logic              s1_ready;
    logic              accept;
    logic              end_col;
    logic              end_row;
    logic [CHAN_W-1:0] ncopy;

    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_stall = !s1_ready;
    assign accept   = in_valid && s1_ready;

    assign end_col = col_reg >= last_col;
    assign end_row = row_reg >= last_row;

    // row-major walk, wrapping at the end of the sprite
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (end_col)
        begin
            col_next = '0;
            row_next = end_row ? '0 : row_reg + CNT_W'(1);
        end
        else
        begin
            col_next = col_reg + CNT_W'(1);
        end
    end

    // channel copy, gray replication and alpha fill
    always_comb
    begin
        ncopy = (cfg.src_chans < cfg.atlas_channels) ?
                cfg.src_chans : cfg.atlas_channels;
        if (ncopy > CH_RGBA)
            ncopy = CH_RGBA;
        pix_next.data = '0;
        pix_next.mask = '0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (CHAN_W'(c) < ncopy)
            begin
                pix_next.data[c] = src[c];
                pix_next.mask[c] = 1'b1;
            end
        end
        if (cfg.src_chans == CH_GRAY && cfg.atlas_channels >= CH_RGB)
        begin
            pix_next.data[1] = src[0];
            pix_next.data[2] = src[0];
            pix_next.mask[1] = 1'b1;
            pix_next.mask[2] = 1'b1;
        end
        if (cfg.src_chans < CH_RGBA && cfg.atlas_channels == CH_RGBA)
        begin
            pix_next.data[3] = OPAQUE;
            pix_next.mask[3] = 1'b1;
        end
        pix_next.last = end_col && end_row;
    end

    // counters and stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (s1_ready)
                s1_valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= pix_next;
            sum_row_reg <= RS_W'(row_reg) + RS_W'(cfg.sprite_y);
            sum_col_reg <= RS_W'(col_reg) + RS_W'(cfg.sprite_x);
        end
    end

    assign s1_valid   = s1_valid_reg;
    assign s1_pix     = s1_pix_reg;
    assign s1_sum_row = sum_row_reg;
    assign s1_sum_col = sum_col_reg;

endmodule

// File: rtl/core/sbce_addr.sv
// address multiply stages and the result register
module sbce_addr #(
    parameter int RS_W = 13
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s1_valid,
    input  sbce_pkg::pix_t                s1_pix,
    input  logic [RS_W-1:0]               s1_sum_row,
    input  logic [RS_W-1:0]               s1_sum_col,
    input  sbce_pkg::cfg_t                cfg,
    output logic                          s2_ready,
    input  logic                          out_stall,
    output logic                          out_valid,
    output sbce_pkg::pix_t                out_pix,
    output logic [sbce_pkg::ADDR_W-1:0]   dest_address
);
    import sbce_pkg::*;

    localparam int PROD_W = RS_W + SIZE_W;
    localparam int P3_W   = ADDR_W + CHAN_W;

    logic              s2_valid_reg;
    pix_t              s2_pix_reg;
    logic [ADDR_W-1:0] lin_reg;
    logic [ADDR_W-1:0] lin_next;
    logic [PROD_W-1:0] row_prod;
    logic              s3_valid_reg;
    pix_t              s3_pix_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [P3_W-1:0]   byte_prod;
    logic              s3_ready;

    assign s3_ready = !s3_valid_reg || !out_stall;
    assign s2_ready = !s2_valid_reg || s3_ready;

    // pixel index in the atlas, modulo the address range
    assign row_prod = PROD_W'(s1_sum_row) * PROD_W'(cfg.atlas_width);
    assign lin_next = row_prod[ADDR_W-1:0] + ADDR_W'(s1_sum_col);

    // scale to bytes
    assign byte_prod = P3_W'(lin_reg) * P3_W'(cfg.atlas_channels);

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_ready)
                s2_valid_reg <= s1_valid;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid)
        begin
            s2_pix_reg <= s1_pix;
            lin_reg    <= lin_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_pix_reg <= s2_pix_reg;
            addr_reg   <= byte_prod[ADDR_W-1:0];
        end
    end

    assign out_valid    = s3_valid_reg;
    assign out_pix      = s3_pix_reg;
    assign dest_address = addr_reg;

endmodule

// File: rtl/core/sprite_blit_channel_expand.sv
// top level of the sprite blit with pixel format conversion
//
//  channel   handshake            payload
//  in        in_valid / in_stall  src_c0 .. src_c3
//  out       out_valid/out_stall  dest_address, out_c0 .. out_c3, write_mask, last_pixel
//  cfg       cfg_we               cfg_index, cfg_data
//
// one pixel per cycle sustained while out_stall is low; a pixel goes through the
// input register, row multiply register and byte scale result register in order
// asynchronous active-low reset clears the counters and stage valids and loads the
// configuration registers with their reset values; payload registers are not reset
// a stall on the output backs up through the stages; bubbles are squeezed out, so
// input is taken while a result waits as long as an earlier stage is free
module sprite_blit_channel_expand #(
    parameter int MAX_ATLAS_SIDE = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [sbce_pkg::BYTE_W-1:0]        src_c0,
    input  logic [sbce_pkg::BYTE_W-1:0]        src_c1,
    input  logic [sbce_pkg::BYTE_W-1:0]        src_c2,
    input  logic [sbce_pkg::BYTE_W-1:0]        src_c3,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [sbce_pkg::ADDR_W-1:0]        dest_address,
    output logic [sbce_pkg::BYTE_W-1:0]        out_c0,
    output logic [sbce_pkg::BYTE_W-1:0]        out_c1,
    output logic [sbce_pkg::BYTE_W-1:0]        out_c2,
    output logic [sbce_pkg::BYTE_W-1:0]        out_c3,
    output logic [sbce_pkg::NUM_CH-1:0]        write_mask,
    output logic                               last_pixel,
    input  logic                               cfg_we,
    input  logic [sbce_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sbce_pkg::SIZE_W-1:0]        cfg_data
);
    import sbce_pkg::*;

    localparam int CNT_W = $clog2(MAX_ATLAS_SIDE);
    localparam int RS_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    cfg_t             cfg;
    logic [CNT_W-1:0] last_col;
    logic [CNT_W-1:0] last_row;
    pix_bytes_t       src;
    logic             s2_ready;
    logic             s1_valid;
    pix_t             s1_pix;
    logic [RS_W-1:0]  s1_sum_row;
    logic [RS_W-1:0]  s1_sum_col;
    pix_t             out_pix;

    assign src = {src_c3, src_c2, src_c1, src_c0};

    sbce_regs #(
        .MAX_SIDE (MAX_ATLAS_SIDE),
        .CNT_W    (CNT_W)
    ) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .last_col  (last_col),
        .last_row  (last_row)
    );

    sbce_front #(
        .CNT_W (CNT_W),
        .RS_W  (RS_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .src        (src),
        .cfg        (cfg),
        .last_col   (last_col),
        .last_row   (last_row),
        .s2_ready   (s2_ready),
        .s1_valid   (s1_valid),
        .s1_pix     (s1_pix),
        .s1_sum_row (s1_sum_row),
        .s1_sum_col (s1_sum_col)
    );

    sbce_addr #(
        .RS_W (RS_W)
    ) u_addr (
        .clk          (clk),
        .rst_n        (rst_n),
        .s1_valid     (s1_valid),
        .s1_pix       (s1_pix),
        .s1_sum_row   (s1_sum_row),
        .s1_sum_col   (s1_sum_col),
        .cfg          (cfg),
        .s2_ready     (s2_ready),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .out_pix      (out_pix),
        .dest_address (dest_address)
    );

    // unpack the result bytes
    assign out_c0     = out_pix.data[0];
    assign out_c1     = out_pix.data[1];
    assign out_c2     = out_pix.data[2];
    assign out_c3     = out_pix.data[3];
    assign write_mask = out_pix.mask;
    assign last_pixel = out_pix.last;

endmodule

// File: rtl/core/sbce_checker.sv
// port-level checks for the sprite blit, bound to the top level
module sbce_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_stall,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic [sbce_pkg::ADDR_W-1:0]        dest_address,
    input logic [sbce_pkg::BYTE_W-1:0]        out_c0,
    input logic [sbce_pkg::BYTE_W-1:0]        out_c1,
    input logic [sbce_pkg::BYTE_W-1:0]        out_c2,
    input logic [sbce_pkg::BYTE_W-1:0]        out_c3,
    input logic [sbce_pkg::NUM_CH-1:0]        write_mask,
    input logic                               last_pixel
);
    import sbce_pkg::*;

    // a stalled result stays offered
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(dest_address) && $stable(out_c0)
            && $stable(out_c1) && $stable(out_c2) && $stable(out_c3)
            && $stable(write_mask) && $stable(last_pixel))
        else $error("result payload changed while stalled");

    // bytes that are not written are zero
    a_masked_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (write_mask[0] || out_c0 == '0) && (write_mask[1] || out_c1 == '0)
            && (write_mask[2] || out_c2 == '0) && (write_mask[3] || out_c3 == '0))
        else $error("unmasked byte not zero");

    // with the result register empty the whole pipe can move, so input is taken
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty result register");

endmodule

bind sprite_blit_channel_expand sbce_checker u_sbce_checker (.*);

// File: tb/tb_sprite_blit_channel_expand.sv
// self-checking testbench for the sprite blit with channel expansion
module tb_sprite_blit_channel_expand;

    import sbce_pkg::*;

    localparam int ITEM_TARGET    = 1100;
    localparam int QUIET_TAIL     = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PIPE_LATENCY   = 3;
    localparam int SMALL_AREA     = 128;
    localparam int MAX_SIDE       = 4096;

    // index with no register behind it, written as noise
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // one atlas write as seen on the output channel
    typedef struct {
        logic [ADDR_W-1:0] addr;
        pix_t              pix;
    } atlas_write_t;

    // model of the blit: register copy, pixel counters, queue of writes in flight
    class atlas_write_tracker;
        logic [SIZE_W-1:0] atlas_width;
        logic [CHAN_W-1:0] atlas_channels;
        logic [CHAN_W-1:0] src_chans;
        logic [POS_W-1:0]  sprite_x;
        logic [POS_W-1:0]  sprite_y;
        logic [SIZE_W-1:0] spr_w;
        logic [SIZE_W-1:0] spr_h;
        logic [POS_W-1:0]  column;
        logic [POS_W-1:0]  row;
        atlas_write_t      writes_in_flight[$];
        int                errors;
        int                checked;
        int                sprite_ends;

        function new();
            atlas_width     = RST_ATLAS_WIDTH;
            atlas_channels  = RST_CHANNELS;
            src_chans       = RST_CHANNELS;
            sprite_x        = RST_POS;
            sprite_y        = RST_POS;
            spr_w           = RST_SPRITE_SIZE;
            spr_h           = RST_SPRITE_SIZE;
            column          = '0;
            row             = '0;
            errors          = 0;
            checked         = 0;
            sprite_ends     = 0;
        endfunction

        // zero counts as one, anything above the largest side as the largest side
        static function int unsigned clamp_side(input int unsigned v);
            if (v == 0)
                return 1;
            if (v > MAX_SIDE)
                return MAX_SIDE;
            return v;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] value);
            case (idx)
                REG_ATLAS_WIDTH:     atlas_width     = value;
                REG_ATLAS_CHANNELS:  atlas_channels  = value[CHAN_W-1:0];
                REG_SRC_CHANS:       src_chans       = value[CHAN_W-1:0];
                REG_SPRITE_X:        sprite_x        = value[POS_W-1:0];
                REG_SPRITE_Y:        sprite_y        = value[POS_W-1:0];
                REG_SPR_W:           spr_w           = value;
                REG_SPR_H:           spr_h           = value;
                default: ;
            endcase
        endfunction

        function int outstanding();
            return writes_in_flight.size();
        endfunction

        // accepted source pixel: work out the atlas write it causes
        function void take_pixel(input pix_bytes_t src);
            atlas_write_t      w;
            int unsigned       side_w;
            int unsigned       side_h;
            int unsigned       ncopy;
            bit                end_col;
            bit                end_row;
            longint unsigned   offset;

            side_w  = clamp_side(spr_w);
            side_h  = clamp_side(spr_h);
            end_col = column >= side_w - 1;
            end_row = row >= side_h - 1;

            // copy the channels both formats share, at most four bytes exist
            w.pix.data = '0;
            w.pix.mask = '0;
            ncopy = (src_chans < atlas_channels) ? src_chans : atlas_channels;
            if (ncopy > NUM_CH)
                ncopy = NUM_CH;
            for (int c = 0; c < ncopy; c++)
            begin
                w.pix.data[c] = src[c];
                w.pix.mask[c] = 1'b1;
            end

            // gray spread over green and blue
            if (src_chans == CH_GRAY && atlas_channels >= CH_RGB)
            begin
                w.pix.data[1] = src[0];
                w.pix.data[2] = src[0];
                w.pix.mask[1] = 1'b1;
                w.pix.mask[2] = 1'b1;
            end

            // opaque alpha when the source has none
            if (src_chans < CH_RGBA && atlas_channels == CH_RGBA)
            begin
                w.pix.data[3] = OPAQUE;
                w.pix.mask[3] = 1'b1;
            end

            // byte address, wrapping at the address width
            offset = (longint'(row) + longint'(sprite_y)) * longint'(atlas_width)
                   + longint'(column) + longint'(sprite_x);
            offset = offset * longint'(atlas_channels);
            w.addr = offset[ADDR_W-1:0];
            w.pix.last = end_col && end_row;

            // advance the raster position
            if (end_col)
            begin
                column = '0;
                row    = end_row ? '0 : row + 1'b1;
            end
            else
            begin
                column = column + 1'b1;
            end

            writes_in_flight = {writes_in_flight, w};
        endfunction

        local function void check_field(input string name, input longint unsigned want,
                                         input longint unsigned got);
            if (want != got)
            begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        // accepted output transaction: compare with the oldest pending write
        function void match_write(input logic [ADDR_W-1:0] addr, input pix_bytes_t bytes,
                                  input logic [NUM_CH-1:0] mask, input logic last);
            atlas_write_t w;

            if (writes_in_flight.size() == 0)
            begin
                $error("output transaction with no pending write: address 0x%0h", addr);
                errors++;
                return;
            end
            w = writes_in_flight.pop_front();
            checked++;
            if (last)
                sprite_ends++;
            check_field("dest_address", w.addr, addr);
            check_field("out_c0", w.pix.data[0], bytes[0]);
            check_field("out_c1", w.pix.data[1], bytes[1]);
            check_field("out_c2", w.pix.data[2], bytes[2]);
            check_field("out_c3", w.pix.data[3], bytes[3]);
            check_field("write_mask", w.pix.mask, mask);
            check_field("last_pixel", w.pix.last, last);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [BYTE_W-1:0]     src_c0;
    logic [BYTE_W-1:0]     src_c1;
    logic [BYTE_W-1:0]     src_c2;
    logic [BYTE_W-1:0]     src_c3;
    logic                  out_valid;
    logic                  out_stall;
    logic [ADDR_W-1:0]     dest_address;
    logic [BYTE_W-1:0]     out_c0;
    logic [BYTE_W-1:0]     out_c1;
    logic [BYTE_W-1:0]     out_c2;
    logic [BYTE_W-1:0]     out_c3;
    logic [NUM_CH-1:0]     write_mask;
    logic                  last_pixel;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [SIZE_W-1:0]     cfg_data;

    atlas_write_tracker    tracker;
    bit                    send_gaps_on;
    bit                    recv_stalls_on;
    int                    pixels_sent;
    int                    config_count;
    int                    quiet_cycles;

    sprite_blit_channel_expand dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .src_c0       (src_c0),
        .src_c1       (src_c1),
        .src_c2       (src_c2),
        .src_c3       (src_c3),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .dest_address (dest_address),
        .out_c0       (out_c0),
        .out_c1       (out_c1),
        .out_c2       (out_c2),
        .out_c3       (out_c3),
        .write_mask   (write_mask),
        .last_pixel   (last_pixel),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // output stall in random bursts
    initial
    begin : stall_gen
        int unsigned burst;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (recv_stalls_on && $urandom_range(0, 3) == 0)
            begin
                burst = $urandom_range(1, 9);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // transaction monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (in_valid && !in_stall)
                tracker.take_pixel({src_c3, src_c2, src_c1, src_c0});
            if (out_valid && !out_stall)
                tracker.match_write(dest_address, {out_c3, out_c2, out_c1, out_c0},
                                    write_mask, last_pixel);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", quiet_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // present one pixel and hold it until taken
    task automatic send_pixel(input pix_bytes_t bytes);
        in_valid <= 1'b1;
        src_c0   <= bytes[0];
        src_c1   <= bytes[1];
        src_c2   <= bytes[2];
        src_c3   <= bytes[3];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pixels_sent++;
    endtask

    // stop sending and wait until every pending write has come out
    task automatic drain_writes();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (tracker.outstanding() != 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[SIZE_W-1:0];
        @(posedge clk);
        tracker.write_reg(idx, value[SIZE_W-1:0]);
    endtask

    // full register set, only with the pipeline empty
    task automatic set_config(input int unsigned aw, input int unsigned ac,
                              input int unsigned sc, input int unsigned sx,
                              input int unsigned sy, input int unsigned sw,
                              input int unsigned sh);
        drain_writes();
        write_reg(REG_ATLAS_WIDTH, aw);
        write_reg(REG_ATLAS_CHANNELS, ac);
        write_reg(REG_SRC_CHANS, sc);
        write_reg(REG_SPRITE_X, sx);
        write_reg(REG_SPRITE_Y, sy);
        write_reg(REG_SPR_W, sw);
        write_reg(REG_SPR_H, sh);
        write_reg(REG_UNUSED, $urandom_range(0, 8191));
        cfg_we <= 1'b0;
        config_count++;
    endtask

    // run of random pixels, with sender gaps when enabled
    task automatic send_random(input int count);
        pix_bytes_t bytes;
        for (int i = 0; i < count; i++)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                case ($urandom_range(0, 7))
                    0:       bytes[c] = 8'h00;
                    1:       bytes[c] = 8'hff;
                    default: bytes[c] = 8'($urandom_range(0, 255));
                endcase
            end
            if (send_gaps_on && $urandom_range(0, 5) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            send_pixel(bytes);
        end
    endtask

    initial
    begin : main
        int unsigned aw;
        int unsigned ac;
        int unsigned sc;
        int unsigned sw;
        int unsigned sh;
        int unsigned area;
        int          count;

        tracker        = new();
        pixels_sent    = 0;
        config_count   = 0;
        quiet_cycles   = 0;
        send_gaps_on   = 1'b0;
        recv_stalls_on = 1'b0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        src_c0    <= '0;
        src_c1    <= '0;
        src_c2    <= '0;
        src_c3    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values, byte extremes
        send_pixel(32'h00000000);
        send_pixel(32'hffffffff);

        // gray into rgba, address past the top of the atlas space
        set_config(8191, 4, 1, 4095, 4095, 2, 2);
        send_pixel(32'haaaaaaaa);
        send_pixel(32'h55555555);
        send_pixel(32'h0000005a);
        send_pixel(32'hffffffa5);

        // gray into rgb, narrowest atlas
        set_config(1, 3, 1, 0, 0, 1, 1);
        send_pixel(32'h123456c3);

        // rgb into rgba, alpha filled
        recv_stalls_on = 1'b1;
        set_config(4096, 4, 3, 10, 20, 3, 1);
        send_pixel(32'h01020304);
        send_pixel(32'hfffefdfc);
        send_pixel(32'h80808080);

        // rgba into a single channel atlas
        set_config(100, 1, 4, 7, 9, 1, 1);
        send_pixel(32'h11223344);

        // no sprite channels, then no atlas channels
        set_config(300, 4, 0, 1, 1, 1, 1);
        send_pixel(32'hdeadbeef);
        set_config(300, 0, 4, 1, 1, 1, 1);
        send_pixel(32'hcafef00d);

        // channel counts above four
        set_config(50, 7, 5, 2, 3, 1, 1);
        send_pixel(32'h0f1e2d3c);
        set_config(50, 5, 2, 2, 3, 1, 1);
        send_pixel(32'hf0e1d2c3);

        // zero width, oversized height, zero atlas width
        set_config(0, 4, 4, 4095, 0, 0, 8191);
        send_random(3);

        // height shrunk under the current row: that row becomes the last one
        set_config(0, 4, 4, 4095, 0, 0, 2);
        send_random(1);

        // width above the largest side
        set_config(64, 2, 2, 0, 4095, 4097, 1);
        send_random(2);

        // random phases: mostly whole small sprites, some partial ones and wild settings
        while (pixels_sent < ITEM_TARGET)
        begin
            if (pixels_sent >= ITEM_TARGET - QUIET_TAIL)
            begin
                send_gaps_on   = 1'b0;
                recv_stalls_on = 1'b0;
            end
            else
            begin
                send_gaps_on   = $urandom_range(0, 3) != 0;
                recv_stalls_on = $urandom_range(0, 3) != 0;
            end

            if ($urandom_range(0, 7) == 0)
            begin
                aw = $urandom_range(0, 8191);
                ac = $urandom_range(0, 7);
                sc = $urandom_range(0, 7);
                sw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 6);
                sh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 6);
            end
            else
            begin
                aw = $urandom_range(1, 4096);
                ac = $urandom_range(1, 4);
                sc = $urandom_range(1, 4);
                if ($urandom_range(0, 9) == 0)
                begin
                    sw = $urandom_range(9, 64);
                    sh = $urandom_range(1, 2);
                end
                else
                begin
                    sw = $urandom_range(1, 8);
                    sh = $urandom_range(1, 8);
                end
            end
            set_config(aw, ac, sc, $urandom_range(0, 4095), $urandom_range(0, 4095), sw, sh);

            area = atlas_write_tracker::clamp_side(sw) * atlas_write_tracker::clamp_side(sh);
            if (area <= SMALL_AREA)
                count = area * $urandom_range(1, 3);
            else
                count = $urandom_range(1, 40);
            if ($urandom_range(0, 3) == 0)
                count += $urandom_range(1, 7);
            // keep the total near the target
            if (count > ITEM_TARGET - pixels_sent)
                count = ITEM_TARGET - pixels_sent;
            send_random(count);
        end

        // let the pipeline empty, then keep watching for stray outputs
        drain_writes();
        repeat (PIPE_LATENCY + 4) @(posedge clk);

        if (tracker.outstanding() != 0)
        begin
            $error("%0d expected writes never came out", tracker.outstanding());
            tracker.errors++;
        end

        $display("sent %0d pixels over %0d register settings", pixels_sent, config_count);
        $display("checked %0d output transactions, %0d sprite ends, %0d errors",
                 tracker.checked, tracker.sprite_ends, tracker.errors);
        if (tracker.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: sprite_blit_channel_expand.f
rtl/core/sbce_pkg.sv
rtl/core/sbce_regs.sv
rtl/core/sbce_front.sv
rtl/core/sbce_addr.sv
rtl/core/sprite_blit_channel_expand.sv
rtl/core/sbce_checker.sv
tb/tb_sprite_blit_channel_expand.sv
